@@ sv/assert_macros.svh @@
// Assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked on every clock, off during reset
`define ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication
`define ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

@@ sv/sha_pkg.sv @@
package sha_pkg;
	localparam int unsigned BlockBytes = 64;
	localparam int unsigned Rounds = 64;
	localparam int unsigned TotalW = 61;
	localparam logic [7:0] PadByte = 8'h80;
	localparam int unsigned LenPos = 56;

	typedef logic [31:0] word_t;

	localparam word_t RoundConst [64] = '{
		32'h428A2F98, 32'h71374491, 32'hB5C0FBCF, 32'hE9B5DBA5,
		32'h3956C25B, 32'h59F111F1, 32'h923F82A4, 32'hAB1C5ED5,
		32'hD807AA98, 32'h12835B01, 32'h243185BE, 32'h550C7DC3,
		32'h72BE5D74, 32'h80DEB1FE, 32'h9BDC06A7, 32'hC19BF174,
		32'hE49B69C1, 32'hEFBE4786, 32'h0FC19DC6, 32'h240CA1CC,
		32'h2DE92C6F, 32'h4A7484AA, 32'h5CB0A9DC, 32'h76F988DA,
		32'h983E5152, 32'hA831C66D, 32'hB00327C8, 32'hBF597FC7,
		32'hC6E00BF3, 32'hD5A79147, 32'h06CA6351, 32'h14292967,
		32'h27B70A85, 32'h2E1B2138, 32'h4D2C6DFC, 32'h53380D13,
		32'h650A7354, 32'h766A0ABB, 32'h81C2C92E, 32'h92722C85,
		32'hA2BFE8A1, 32'hA81A664B, 32'hC24B8B70, 32'hC76C51A3,
		32'hD192E819, 32'hD6990624, 32'hF40E3585, 32'h106AA070,
		32'h19A4C116, 32'h1E376C08, 32'h2748774C, 32'h34B0BCB5,
		32'h391C0CB3, 32'h4ED8AA4A, 32'h5B9CCA4F, 32'h682E6FF3,
		32'h748F82EE, 32'h78A5636F, 32'h84C87814, 32'h8CC70208,
		32'h90BEFFFA, 32'hA4506CEB, 32'hBEF9A3F7, 32'hC67178F2
	};

	localparam word_t InitHash [8] = '{
		32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
		32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
	};

	// control from sequencer to round unit
	typedef struct packed {
		logic       load;  // copy chaining words into working set
		logic       step;  // run one round
		logic       fold;  // add working set into chaining words
		logic       init;  // restore initial hash values
		logic [5:0] rnd;
	} rnd_ctl_t;

	function automatic word_t rotr(input word_t x, input int unsigned n);
		rotr = (x >> n) | (x << (32 - n));
	endfunction
endpackage

@@ sv/sha_ram.sv @@
module sha_ram #(
	parameter int unsigned Width = 8,
	parameter int unsigned Depth = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem_q [Depth];

	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end
endmodule

@@ sv/sha_round.sv @@
module sha_round (
	input  logic              clk,
	input  logic              arst_n,
	input  sha_pkg::rnd_ctl_t ctl,
	input  sha_pkg::word_t    w_in,     // used for rounds 0..15
	input  logic [2:0]        hidx,
	output sha_pkg::word_t    hword
);
	import sha_pkg::*;

	word_t h_q [8];
	word_t v_q [8];
	word_t sch_q [16];
	word_t w, s0, s1, t1, t2, a, e;
	logic [3:0] r4;

	assign r4 = ctl.rnd[3:0];
	assign a = v_q[0];
	assign e = v_q[4];
	assign hword = h_q[hidx];

	always_comb begin
		s1 = rotr(sch_q[r4 - 4'd2], 17) ^ rotr(sch_q[r4 - 4'd2], 19) ^ (sch_q[r4 - 4'd2] >> 10);
		s0 = rotr(sch_q[r4 - 4'd15], 7) ^ rotr(sch_q[r4 - 4'd15], 18)
			^ (sch_q[r4 - 4'd15] >> 3);
		w = (ctl.rnd < 6'd16) ? w_in : s1 + sch_q[r4 - 4'd7] + s0 + sch_q[r4];
		t1 = v_q[7] + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25))
			+ ((e & v_q[5]) ^ (~e & v_q[6])) + RoundConst[ctl.rnd] + w;
		t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22))
			+ ((a & v_q[1]) ^ (a & v_q[2]) ^ (v_q[1] & v_q[2]));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 8; i++) h_q[i] <= InitHash[i];
		end else if (ctl.init) begin
			for (int i = 0; i < 8; i++) h_q[i] <= InitHash[i];
		end else if (ctl.fold) begin
			for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + v_q[i];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			for (int i = 0; i < 8; i++) v_q[i] <= h_q[i];
		end else if (ctl.step) begin
			v_q[0] <= t1 + t2;
			v_q[1] <= v_q[0];
			v_q[2] <= v_q[1];
			v_q[3] <= v_q[2];
			v_q[4] <= v_q[3] + t1;
			v_q[5] <= v_q[4];
			v_q[6] <= v_q[5];
			v_q[7] <= v_q[6];
			sch_q[r4] <= w;
		end
	end
endmodule

@@ sv/sha256_message_hasher.sv @@
// SHA-256 hasher, one byte per transfer in, eight digest-word transfers out.
// Bytes that neither close a block nor end the message can follow back to back.
// A byte that closes a block adds byte fetches for rounds 0..15, 64 rounds and one fold.
// Message end: padding to end of block (again for an extra block), compression, 8 words out.
// Async reset (arst_n low) restores initial hash values and zero length.
module sha256_message_hasher (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  message_byte,
	input  logic        byte_present,
	input  logic        message_end,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] digest_word,
	output logic [2:0]  word_index,
	output logic        final_word
);
	import sha_pkg::*;
	`include "assert_macros.svh"

	typedef enum logic [2:0] {
		S_IDLE, S_PAD, S_RD, S_RND, S_FOLD, S_OUT
	} state_t;

	state_t       state_q;
	logic [TotalW-1:0] total_q; // byte count
	logic         fin_q;       // message end pending
	logic         last_q;      // block being compressed holds length
	logic [5:0]   pos_q;       // padding write pointer
	logic [6:0]   rnd_q;       // round counter; fetch in lockstep
	logic [1:0]   bsel_q;
	word_t        wacc_q;
	logic [2:0]   oidx_q;
	logic [63:0]  bits;
	logic [2:0]   len_idx;     // length byte, 7 = most significant

	// buffer ram
	logic        we;
	logic [5:0]  waddr, raddr;
	logic [7:0]  wdata, rdata;
	rnd_ctl_t    ctl;

	sha_ram #(.Width(8), .Depth(BlockBytes)) u_buf (
		.clk, .we, .waddr, .wdata, .raddr, .rdata
	);

	// last byte of the word lands on rdata in the round cycle itself
	logic [2:0] hidx;
	word_t      hword;
	sha_round u_rnd (
		.clk, .arst_n, .ctl, .w_in({wacc_q[23:0], rdata}), .hidx, .hword
	);

	assign bits = {total_q, 3'b000};
	assign len_idx = 3'd7 - pos_q[2:0];
	assign in_ready = (state_q == S_IDLE);
	assign out_valid = (state_q == S_OUT);
	assign digest_word = hword;
	assign word_index = oidx_q;
	assign final_word = (oidx_q == 3'd7);
	assign hidx = oidx_q;

	// buffer writes, read address and round control; rdata is registered, arriving in the cycle
	// after its address; bsel_q counts byte fetches in S_RD (4 bytes per word, word then a round)
	always_comb begin
		we = 1'b0;
		waddr = pos_q;
		wdata = 8'h00;
		raddr = {rnd_q[3:0], bsel_q};
		ctl = '0;
		ctl.rnd = rnd_q[5:0];
		if (state_q == S_IDLE && in_valid && byte_present) begin
			we = 1'b1;
			waddr = total_q[5:0];
			wdata = message_byte;
		end else if (state_q == S_PAD) begin
			we = 1'b1;
			if (pos_q == total_q[5:0] && !last_q) wdata = PadByte;
			else if (last_q && pos_q >= 6'(LenPos))
				wdata = bits[{len_idx, 3'b000} +: 8];
			else wdata = 8'h00;
		end
		if (state_q == S_RND) ctl.step = 1'b1;
		if (state_q == S_FOLD) ctl.fold = 1'b1;
		if (state_q == S_OUT && out_ready && oidx_q == 3'd7) ctl.init = 1'b1;
		if (state_q == S_RD && rnd_q == 7'd0 && bsel_q == 2'd0) ctl.load = 1'b1;
	end

	// Sequencer. S_PAD first writes 0x80 at the fill level (pass with last_q=0
	// if the length will not fit), else zero/length to end of block.
	logic rd_phase_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			total_q <= '0;
			fin_q <= 1'b0;
			last_q <= 1'b0;
			pos_q <= '0;
			rnd_q <= '0;
			bsel_q <= '0;
			oidx_q <= '0;
			rd_phase_q <= 1'b0;
			wacc_q <= '0;
		end else begin
			case (state_q)
				S_IDLE: if (in_valid) begin
					fin_q <= message_end;
					if (byte_present) total_q <= total_q + 61'd1;
					rnd_q <= '0;
					bsel_q <= '0;
					rd_phase_q <= 1'b0;
					if (byte_present && total_q[5:0] == 6'd63) begin
						state_q <= S_RD;
						last_q <= 1'b0;
					end else if (message_end) begin
						state_q <= S_PAD;
						pos_q <= byte_present ? total_q[5:0] + 6'd1 : total_q[5:0];
						last_q <= 1'b0;
					end
				end
				S_PAD: begin
					// first pass: pad byte at pos_q == fill; zeros follow, then the length if it fits
					// total_q already counts all bytes
					pos_q <= pos_q + 6'd1;
					if (pos_q == 6'd63) begin
						state_q <= S_RD;
					end else if (!last_q && pos_q == total_q[5:0]
						&& total_q[5:0] < 6'(LenPos)) begin
						last_q <= 1'b1;
					end
					if (last_q && pos_q == 6'd63) fin_q <= 1'b0;
				end
				S_RD: begin
					// 4 fetches then one round
					rd_phase_q <= 1'b1;
					if (rd_phase_q) wacc_q <= {wacc_q[23:0], rdata};
					bsel_q <= bsel_q + 2'd1;
					if (bsel_q == 2'd3) begin
						state_q <= S_RND;
						bsel_q <= 2'd0;
					end
				end
				S_RND: begin
					if (rd_phase_q && rnd_q < 7'd16) wacc_q <= {wacc_q[23:0], rdata};
					rd_phase_q <= 1'b0;
					rnd_q <= rnd_q + 7'd1;
					if (rnd_q == 7'(Rounds - 1)) state_q <= S_FOLD;
					else if (rnd_q < 7'd15) state_q <= S_RD;
				end
				S_FOLD: begin
					rnd_q <= '0;
					if (last_q) begin
						state_q <= S_OUT;
						oidx_q <= '0;
					end else if (fin_q) begin
						// end byte filled block or no room for length: 0x80 at 0 unless written; then zeros, length
						state_q <= S_PAD;
						pos_q <= 6'd0;
						last_q <= (total_q[5:0] != 6'd0);
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_OUT: if (out_ready) begin
					oidx_q <= oidx_q + 3'd1;
					if (oidx_q == 3'd7) begin
						state_q <= S_IDLE;
						total_q <= '0;
						last_q <= 1'b0;
						fin_q <= 1'b0;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`ASSERT_IMP(a_excl, out_valid, !in_ready, "input accepted while output pending")
	`ASSERT_NXT(a_wrap, out_valid && out_ready && final_word, in_ready,
		"not idle after final digest word")
	`ASSERT_NXT(a_total_clr, out_valid && out_ready && final_word, total_q == '0,
		"length not cleared after digest")
endmodule
